// ===== rtl/core/rlcs_pkg.sv =====
// Shared constants and types for the RGB LED chain serializer.
package rlcs_pkg;

    localparam int LED_COUNT_DEF = 12;

    localparam int BYTE_W   = 8;
    localparam int COLOUR_W = 3 * BYTE_W;
    localparam int SYM_W    = 5;
    localparam int GROUP_W  = BYTE_W * SYM_W;

    localparam logic [BYTE_W-1:0] FLUSH_INDEX = 8'hFF;

    localparam logic [SYM_W-1:0] ONE_PATTERN_RST  = 5'h1C;
    localparam logic [SYM_W-1:0] ZERO_PATTERN_RST = 5'h10;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from the word address bit of paddr.
    typedef enum logic {
        REG_ONE_PATTERN  = 1'b0,
        REG_ZERO_PATTERN = 1'b1
    } t_reg_idx;

endpackage

// ===== rtl/core/rlcs_if.sv =====
// Valid/ready channel interfaces for colour writes and symbol groups.
interface rlcs_pix_if;
    logic                        valid;
    logic                        ready;
    logic [rlcs_pkg::BYTE_W-1:0] led_index;
    logic [rlcs_pkg::BYTE_W-1:0] green_level;
    logic [rlcs_pkg::BYTE_W-1:0] red_level;
    logic [rlcs_pkg::BYTE_W-1:0] blue_level;

    modport source (output valid, led_index, green_level, red_level, blue_level,
                    input ready);
    modport sink (input valid, led_index, green_level, red_level, blue_level,
                  output ready);
endinterface

interface rlcs_grp_if;
    logic                         valid;
    logic                         ready;
    logic [rlcs_pkg::GROUP_W-1:0] symbol_group;
    logic                         last_group;

    modport source (output valid, symbol_group, last_group, input ready);
    modport sink (input valid, symbol_group, last_group, output ready);
endinterface

// ===== rtl/core/rgb_led_chain_serializer.sv =====
// Top level of the RGB LED chain serializer: store, sequencer, encoder and APB registers.
//
//  Port      Dir  Protocol    Beat contents
//  i_pix     in   valid/ready led_index, green_level, red_level, blue_level
//  o_grp     out  valid/ready symbol_group (40 bits), last_group
//  APB       in   APB write   one_pattern at 0x0, zero_pattern at 0x4
//
// A colour write or an ignored index is taken while the sequencer is idle, so such
// beats can arrive back to back. A flush (index 255) walks the store, LED 0 first
// and green, red, blue within each LED, and produces 3 * LED_COUNT groups. For each
// group the sequencer loads the byte read from the store into the shared bit-serial
// encoder (ST_LOAD), shifts it out (ST_SHIFT), registers the result and holds it on
// the output until taken (ST_EMIT), and i_pix is not ready meanwhile.
// The synchronous reset clears the colour store and loads the default patterns.
module rgb_led_chain_serializer #(
    parameter int LED_COUNT = rlcs_pkg::LED_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rlcs_pix_if.sink                        i_pix,
    rlcs_grp_if.source                      o_grp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rlcs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rlcs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rlcs_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    // Colour byte position within an entry, in the order it goes on the line.
    localparam logic [1:0] COL_GREEN = 2'd0;
    localparam logic [1:0] COL_RED   = 2'd1;
    localparam logic [1:0] COL_BLUE  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SHIFT,
        ST_EMIT
    } t_state;

    t_state                        r_state;
    logic [IDX_W-1:0]              r_led;
    logic [1:0]                    r_col;
    logic                          r_out_valid;
    logic [rlcs_pkg::GROUP_W-1:0]  r_group;
    logic                          r_last;
    logic [rlcs_pkg::SYM_W-1:0]    r_one_pattern;
    logic [rlcs_pkg::SYM_W-1:0]    r_zero_pattern;

    logic                          pix_beat;
    logic                          grp_beat;
    logic                          store_wr;
    logic                          is_flush;
    logic [rlcs_pkg::COLOUR_W-1:0] rd_colour;
    logic [rlcs_pkg::BYTE_W-1:0]   cur_byte;
    logic                          enc_start;
    logic                          enc_done;
    logic [rlcs_pkg::GROUP_W-1:0]  enc_group;
    logic                          final_group;
    logic                          apb_wr;
    rlcs_pkg::t_reg_idx            reg_idx;

    // Input side is open only between flushes.
    assign i_pix.ready = (r_state == ST_IDLE);
    assign pix_beat    = i_pix.valid && i_pix.ready;
    assign grp_beat    = r_out_valid && o_grp.ready;

    assign is_flush = (i_pix.led_index == rlcs_pkg::FLUSH_INDEX);
    assign store_wr = pix_beat && (i_pix.led_index < rlcs_pkg::BYTE_W'(LED_COUNT));

    rlcs_store #(
        .LED_COUNT (LED_COUNT),
        .IDX_W     (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (store_wr),
        .i_wr_idx  (i_pix.led_index[IDX_W-1:0]),
        .i_wr_data ({i_pix.green_level, i_pix.red_level, i_pix.blue_level}),
        .i_rd_idx  (r_led),
        .o_rd_data (rd_colour)
    );

    // Pick the colour byte that the sequencer is on.
    always_comb begin
        unique case (r_col)
            COL_GREEN: cur_byte = rd_colour[3*rlcs_pkg::BYTE_W-1:2*rlcs_pkg::BYTE_W];
            COL_RED:   cur_byte = rd_colour[2*rlcs_pkg::BYTE_W-1:rlcs_pkg::BYTE_W];
            default:   cur_byte = rd_colour[rlcs_pkg::BYTE_W-1:0];
        endcase
    end

    assign enc_start = (r_state == ST_LOAD);

    rlcs_sym_shifter u_shifter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (enc_start),
        .i_byte         (cur_byte),
        .i_one_pattern  (r_one_pattern),
        .i_zero_pattern (r_zero_pattern),
        .o_done         (enc_done),
        .o_group        (enc_group)
    );

    assign final_group = (r_led == IDX_W'(LED_COUNT - 1)) && (r_col == COL_BLUE);

    // Sequencer: walks LEDs and colour bytes, one encoder pass per group.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_led       <= '0;
            r_col       <= COL_GREEN;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (pix_beat && is_flush) begin
                        r_led   <= '0;
                        r_col   <= COL_GREEN;
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_state <= ST_SHIFT;
                end
                ST_SHIFT: begin
                    if (enc_done) begin
                        r_group     <= enc_group;
                        r_last      <= final_group;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (grp_beat) begin
                        r_out_valid <= 1'b0;
                        if (r_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_LOAD;
                            if (r_col == COL_BLUE) begin
                                r_col <= COL_GREEN;
                                r_led <= r_led + 1'b1;
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_grp.valid        = r_out_valid;
    assign o_grp.symbol_group = r_group;
    assign o_grp.last_group   = r_last;

    // APB registers; the word address bit selects the register.
    assign pready  = 1'b1;
    assign apb_wr  = psel && penable && pwrite;
    assign reg_idx = rlcs_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_pattern  <= rlcs_pkg::ONE_PATTERN_RST;
            r_zero_pattern <= rlcs_pkg::ZERO_PATTERN_RST;
        end else if (apb_wr) begin
            unique case (reg_idx)
                rlcs_pkg::REG_ONE_PATTERN:  r_one_pattern  <= pwdata[rlcs_pkg::SYM_W-1:0];
                rlcs_pkg::REG_ZERO_PATTERN: r_zero_pattern <= pwdata[rlcs_pkg::SYM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rlcs_pkg::REG_ONE_PATTERN:
                prdata = rlcs_pkg::APB_DATA_W'(r_one_pattern);
            rlcs_pkg::REG_ZERO_PATTERN:
                prdata = rlcs_pkg::APB_DATA_W'(r_zero_pattern);
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/rlcs_store.sv =====
// Colour store: one 24-bit green-red-blue entry per LED, cleared at reset.
module rlcs_store #(
    parameter int LED_COUNT = rlcs_pkg::LED_COUNT_DEF,
    parameter int IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [IDX_W-1:0]              i_wr_idx,
    input  logic [rlcs_pkg::COLOUR_W-1:0] i_wr_data,
    input  logic [IDX_W-1:0]              i_rd_idx,
    output logic [rlcs_pkg::COLOUR_W-1:0] o_rd_data
);

    logic [rlcs_pkg::COLOUR_W-1:0] r_colour [LED_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LED_COUNT; k++) begin
                r_colour[k] <= '0;
            end
        end else if (i_wr_en) begin
            r_colour[i_wr_idx] <= i_wr_data;
        end
    end

    assign o_rd_data = r_colour[i_rd_idx];

endmodule

// ===== rtl/core/rlcs_sym_shifter.sv =====
// Shared bit-serial encoder: turns one byte into eight line symbols, one per cycle.
module rlcs_sym_shifter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rlcs_pkg::BYTE_W-1:0]  i_byte,
    input  logic [rlcs_pkg::SYM_W-1:0]   i_one_pattern,
    input  logic [rlcs_pkg::SYM_W-1:0]   i_zero_pattern,
    output logic                         o_done,
    output logic [rlcs_pkg::GROUP_W-1:0] o_group
);

    localparam int CNT_W = $clog2(rlcs_pkg::BYTE_W);

    logic                         r_busy;
    logic                         r_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [rlcs_pkg::BYTE_W-1:0]  r_byte;
    logic [rlcs_pkg::GROUP_W-1:0] r_group;
    logic [rlcs_pkg::SYM_W-1:0]   sym;

    // Most significant bit goes out first.
    assign sym = r_byte[rlcs_pkg::BYTE_W-1] ? i_one_pattern : i_zero_pattern;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(rlcs_pkg::BYTE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_byte <= i_byte;
        end else if (r_busy) begin
            r_byte  <= {r_byte[rlcs_pkg::BYTE_W-2:0], 1'b0};
            r_group <= {r_group[rlcs_pkg::GROUP_W-rlcs_pkg::SYM_W-1:0], sym};
        end
    end

    assign o_done  = r_done;
    assign o_group = r_group;

endmodule

// ===== verif/rlcs_symbol_check.sv =====
// Checker for the RGB LED chain serializer: tracks the colour store and patterns, compares groups.
module rlcs_symbol_check #(
    parameter int LED_COUNT = rlcs_pkg::LED_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rlcs_pix_if                             i_pix,
    rlcs_grp_if                             i_grp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rlcs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rlcs_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                            pready,
    output int                              o_groups_owed,
    output int                              o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import rlcs_pkg::*;

    typedef struct packed {
        logic [GROUP_W-1:0] symbols;
        logic               last;
    } t_group;

    t_group              owed_groups[$];
    logic [COLOUR_W-1:0] led_colours[LED_COUNT];
    logic [SYM_W-1:0]    one_sym;
    logic [SYM_W-1:0]    zero_sym;
    int                  fail_count = 0;

    // One line symbol per bit, bit 7 ends up in the top five bits.
    function automatic logic [GROUP_W-1:0] encode_level(input logic [BYTE_W-1:0] level);
        logic [GROUP_W-1:0] symbols;
        symbols = '0;
        for (int b = BYTE_W - 1; b >= 0; b--) begin
            symbols = {symbols[GROUP_W-SYM_W-1:0], level[b] ? one_sym : zero_sym};
        end
        return symbols;
    endfunction

    // A flush walks every LED, green then red then blue, and marks the final group.
    task automatic owe_flush_groups();
        t_group grp_exp;
        for (int led = 0; led < LED_COUNT; led++) begin
            for (int c = 2; c >= 0; c--) begin
                grp_exp.symbols = encode_level(led_colours[led][c*BYTE_W +: BYTE_W]);
                grp_exp.last    = (led == LED_COUNT - 1) && (c == 0);
                owed_groups.push_back(grp_exp);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_group grp_exp;
        if (!i_rst_n) begin
            foreach (led_colours[k]) led_colours[k] = '0;
            one_sym  = ONE_PATTERN_RST;
            zero_sym = ZERO_PATTERN_RST;
            owed_groups.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[2]))
                    REG_ONE_PATTERN:  one_sym  = pwdata[SYM_W-1:0];
                    REG_ZERO_PATTERN: zero_sym = pwdata[SYM_W-1:0];
                    default: ;
                endcase
            end

            if (i_grp.valid && i_grp.ready) begin
                if (owed_groups.size() == 0) begin
                    $error("group beat with nothing expected: symbol_group %h last_group %b",
                           i_grp.symbol_group, i_grp.last_group);
                    fail_count++;
                end else begin
                    grp_exp = owed_groups.pop_front();
                    if (i_grp.symbol_group !== grp_exp.symbols) begin
                        $error("symbol_group: expected %h, actual %h",
                               grp_exp.symbols, i_grp.symbol_group);
                        fail_count++;
                    end
                    if (i_grp.last_group !== grp_exp.last) begin
                        $error("last_group: expected %b, actual %b",
                               grp_exp.last, i_grp.last_group);
                        fail_count++;
                    end
                end
            end

            if (i_pix.valid && i_pix.ready) begin
                if (i_pix.led_index == FLUSH_INDEX) begin
                    owe_flush_groups();
                end else if (i_pix.led_index < LED_COUNT) begin
                    led_colours[i_pix.led_index] =
                        {i_pix.green_level, i_pix.red_level, i_pix.blue_level};
                end
            end
        end
        o_groups_owed <= owed_groups.size();
        o_fail_count  <= fail_count;
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the RGB LED chain serializer: clock, reset, stimulus, watchdog and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rlcs_pkg::*;

    localparam int LED_N          = LED_COUNT_DEF;
    localparam int PHASE_ITEMS    = 40;
    // Long receiver hold-off; the sender keeps offering beats meanwhile, so the input
    // stays stalled behind the waiting group.
    localparam int RECV_HOLD      = 300;
    // Cycles left after the last owed group, covering a write still in flight.
    localparam int SETTLE_CYCLES  = 24;
    // The long hold-off is the longest quiet stretch, well beyond a flush group with
    // its random stalls, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 4000;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int groups_owed;
    int fail_count;
    int quiet_cycles = 0;

    // Both sides idle at random while this is set; the last phase clears it.
    bit idle_on  = 1'b1;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    bit hold_req = 1'b0;

    rlcs_pix_if pix ();
    rlcs_grp_if grp ();

    rgb_led_chain_serializer #(
        .LED_COUNT(LED_N)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_pix  (pix),
        .o_grp  (grp),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    rlcs_symbol_check #(
        .LED_COUNT(LED_N)
    ) u_symbol_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_pix        (pix),
        .i_grp        (grp),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_groups_owed(groups_owed),
        .o_fail_count (fail_count)
    );

    // 12 ns clock, starting low.
    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // The watchdog restarts whenever any beat or register write goes through. Values
    // are read right at the edge, so they are the ones the block sampled.
    always @(posedge clk) begin
        if ((pix.valid && pix.ready) || (grp.valid && grp.ready) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver side of the group channel. Every pass makes exactly one assignment to
    // ready and then lets time move, so ready is never lowered and raised in one step.
    initial begin
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                grp.ready <= 1'b0;
                repeat (RECV_HOLD) @(posedge clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                grp.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end else begin
                grp.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offers one beat and returns at the edge where it is taken. Valid stays high on
    // return, so back-to-back beats follow without a gap. An idle burst lowers valid
    // first, and the raise happens only after the idle wait has let an edge pass.
    task automatic send_pixel(input logic [BYTE_W-1:0] idx, input logic [BYTE_W-1:0] green,
                              input logic [BYTE_W-1:0] red, input logic [BYTE_W-1:0] blue);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        pix.valid       <= 1'b1;
        pix.led_index   <= idx;
        pix.green_level <= green;
        pix.red_level   <= red;
        pix.blue_level  <= blue;
        @(posedge clk);
        while (!pix.ready) @(posedge clk);
    endtask

    // Stops offering beats and waits until every owed group has been checked. The owed
    // count is registered, hence the first edge before looking at it. The
    // settle cycles let a final colour write, which owes nothing, finish in the block.
    task automatic drain_groups();
        pix.valid <= 1'b0;
        @(posedge clk);
        while (groups_owed != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write: setup, then access. The extra edge at the end keeps a
    // following write from lowering and raising psel in the same step.
    task automatic write_pattern(input t_reg_idx sel, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Random beats: mostly colour writes to any LED, some flushes, and some indices
    // the block must ignore. Ignored beats do not count toward the phase length.
    task automatic run_random_pixels(input int count);
        int counted;
        int pick;
        counted = 0;
        while (counted < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_pixel(FLUSH_INDEX, 8'($urandom), 8'($urandom), 8'($urandom));
                counted++;
            end else if (pick < 22) begin
                send_pixel(8'($urandom_range(LED_N, 254)),
                           8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                send_pixel(8'($urandom_range(0, LED_N - 1)),
                           8'($urandom), 8'($urandom), 8'($urandom));
                counted++;
            end
        end
    endtask

    initial begin
        rst_n           <= 1'b0;
        pix.valid       <= 1'b0;
        pix.led_index   <= '0;
        pix.green_level <= '0;
        pix.red_level   <= '0;
        pix.blue_level  <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset patterns. A flush of the cleared store comes
        // first, and its level fields carry junk that must be ignored.
        send_pixel(FLUSH_INDEX, 8'h5A, 8'hA5, 8'hFF);
        send_pixel(8'd0, 8'hFF, 8'h00, 8'hAA);
        send_pixel(8'(LED_N - 1), 8'h00, 8'hFF, 8'h55);
        // Indices just past the chain, in the middle and just below the flush index
        // must leave the store alone.
        send_pixel(8'(LED_N), 8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h80, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'd254, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'd5, 8'h81, 8'h7E, 8'h01);
        send_pixel(FLUSH_INDEX, 8'h00, 8'h00, 8'h00);
        drain_groups();

        // Extreme patterns, written with the upper register bits set; only the low
        // five bits may take effect.
        write_pattern(REG_ONE_PATTERN, 32'hFFFF_FFFF);
        write_pattern(REG_ZERO_PATTERN, 32'hFFFF_FFE0);
        send_pixel(8'd0, 8'h00, 8'hFF, 8'h00);
        send_pixel(FLUSH_INDEX, 8'hFF, 8'hFF, 8'hFF);
        // Overwrite the last LED and flush again so the final group changes.
        send_pixel(8'(LED_N - 1), 8'hFF, 8'hFF, 8'hFF);
        send_pixel(FLUSH_INDEX, 8'h00, 8'h00, 8'h00);

        // Back-pressure: the receiver holds off for a long stretch during a flush while
        // the sender keeps offering beats, so the block backs up and stalls its input.
        send_pixel(FLUSH_INDEX, 8'($urandom), 8'($urandom), 8'($urandom));
        hold_req = 1'b1;
        run_random_pixels(PHASE_ITEMS);
        drain_groups();

        // The opposite extremes.
        write_pattern(REG_ONE_PATTERN, {27'($urandom), 5'd0});
        write_pattern(REG_ZERO_PATTERN, {27'($urandom), 5'd31});
        run_random_pixels(PHASE_ITEMS);
        drain_groups();

        // Arbitrary patterns, upper bits random as well.
        write_pattern(REG_ONE_PATTERN, $urandom);
        write_pattern(REG_ZERO_PATTERN, $urandom);
        run_random_pixels(PHASE_ITEMS);
        drain_groups();

        // Back to the reset patterns, and no idling on either side from here on.
        write_pattern(REG_ONE_PATTERN, {27'd0, ONE_PATTERN_RST});
        write_pattern(REG_ZERO_PATTERN, {27'd0, ZERO_PATTERN_RST});
        idle_on = 1'b0;
        run_random_pixels(PHASE_ITEMS);
        drain_groups();

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
